/* sv/dbhr_pkg.sv */
// package for the button debounce / hold / repeat core
// holds the shared constants, register indexes, action codes and entry layout
// no dependencies
package dbhr_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int ADDR_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int TIME_W      = 32;
  localparam int CFG_T_W     = 16;
  localparam int MASK_W      = 4;
  localparam int LEVELS_W    = 4;

  // pending action codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_HOLD    = 2'd3;

  // input item kinds
  localparam logic ITEM_SAMPLE = 1'b0;
  localparam logic ITEM_FETCH  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_HOLD     = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;
  localparam logic [1:0] CFG_MASK     = 2'd3;

  typedef struct packed {
    logic [CFG_T_W-1:0] debounce_time;
    logic [CFG_T_W-1:0] hold_time;
    logic [CFG_T_W-1:0] repeat_interval;
  } cfg_t;

  // per-button state kept in the state ram
  typedef struct packed {
    logic [1:0]        pending;
    logic              repeat_active;
    logic [TIME_W-1:0] last_repeat_time;
    logic [TIME_W-1:0] change_time;
  } btn_entry_t;

  localparam int ENT_W = $bits(btn_entry_t);

endpackage

/* sv/dbhr_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module dbhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/dbhr_update.sv */
// per-button read-modify-write logic for a sample transfer
// depends on dbhr_pkg
module dbhr_update (
  input  dbhr_pkg::btn_entry_t          ent_i,
  input  logic                          deb_i,
  input  logic                          pressed_i,
  input  logic                          rep_en_i,
  input  logic [dbhr_pkg::TIME_W-1:0]   now_i,
  input  dbhr_pkg::cfg_t                cfg_i,
  output dbhr_pkg::btn_entry_t          ent_o,
  output logic                          deb_o,
  output logic                          press_o
);
  import dbhr_pkg::*;

  logic [TIME_W-1:0] since;
  logic [TIME_W-1:0] since_rep;
  logic              rep_act;

  assign since     = now_i - ent_i.change_time;
  assign since_rep = now_i - ent_i.last_repeat_time;

  always_comb begin
    ent_o   = ent_i;
    deb_o   = deb_i;
    press_o = 1'b0;
    rep_act = ent_i.repeat_active;
    if (pressed_i != deb_i) begin
      if (since > TIME_W'(cfg_i.debounce_time)) begin
        deb_o             = pressed_i;
        ent_o.change_time = now_i;
        if (pressed_i) begin
          ent_o.pending = ACT_PRESS;
          press_o       = 1'b1;
        end else begin
          ent_o.pending       = ACT_RELEASE;
          ent_o.repeat_active = 1'b0;
        end
      end
    end else if (pressed_i) begin
      if (since > TIME_W'(cfg_i.hold_time)) begin
        ent_o.pending = ACT_HOLD;
        if (rep_en_i) begin
          rep_act             = 1'b1;
          ent_o.repeat_active = 1'b1;
        end
      end
      // a repeat press wins over hold in the same sample
      if (rep_act && rep_en_i && (since_rep > TIME_W'(cfg_i.repeat_interval))) begin
        ent_o.pending          = ACT_PRESS;
        ent_o.last_repeat_time = now_i;
        press_o                = 1'b1;
      end
    end
  end

endmodule

/* sv/button_debounce_hold_repeat_core.sv */
// top level of the button debounce / hold / repeat core
// depends on dbhr_pkg, dbhr_ram and dbhr_update
//
// Qualifies NUM_BUTTONS active-low buttons. Input transfers on in_* carry
// either a sample (in_tuser low: time in ms and raw pin levels) or a fetch
// (in_tuser high: button index). Every input transfer gives exactly one
// result transfer on out_*: the fetched pending action, the debounced
// pressed flags and whether the sample latched a press.
// Per-button state lives in a small ram; each cycle one entry is read and
// written back in the next, with forwarding when the same entry is read
// while being written.
// A sample makes one ram access per button and a fetch makes one; a run of
// fetches is held back as the queue credit ignores a pop in the same cycle;
// the next item is taken in the cycle its predecessor issues its last ram read.
// A result passes the issue stage, the compute stage and the output queue.
// Results pass through a two-entry output queue; when the receiver stalls
// the queue fills and in_tready drops, nothing is lost.
// Reset (rst_n low, synchronous) restores the register defaults and marks
// all state entries as cleared; no clearing pass is needed.
// Configuration writes are taken at any cycle but are meant for idle periods.
module button_debounce_hold_repeat_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // now_ms[31:0], pin_levels[35:32], button[37:36], zero pad
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // fetched_action[1:0], pressed_levels[5:2], interaction[6]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import dbhr_pkg::*;

  // configuration registers
  cfg_t              cfg_r;
  logic [MASK_W-1:0] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= 16'd50;
      cfg_r.hold_time       <= 16'd1000;
      cfg_r.repeat_interval <= 16'd200;
      mask_r                <= 4'd3;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_DEBOUNCE: cfg_r.debounce_time   <= cfg_wdata;
        CFG_HOLD:     cfg_r.hold_time       <= cfg_wdata;
        CFG_INTERVAL: cfg_r.repeat_interval <= cfg_wdata;
        CFG_MASK:     mask_r                <= cfg_wdata[MASK_W-1:0];
        default:      mask_r                <= mask_r;
      endcase
    end
  end

  // issue stage: holds the current item and walks the buttons
  logic              cur_valid_r;
  logic              cur_act_r;
  logic [TIME_W-1:0] cur_now_r;
  logic [3:0]        cur_pins_r;
  logic [1:0]        cur_btn_r;
  logic [ADDR_W-1:0] idx_r;

  logic              in_fire;
  logic              issue_last;
  logic              issue_fire;
  logic              credit_ok;
  logic [ADDR_W-1:0] rd_addr;
  logic              btn_ok;
  logic [NUM_BUTTONS-1:0] pressed_vec;
  logic [NUM_BUTTONS-1:0] rep_vec;

  // compute stage
  logic              s2_valid_r;
  logic              s2_act_r;
  logic              s2_first_r;
  logic              s2_last_r;
  logic              s2_btn_ok_r;
  logic              s2_pressed_r;
  logic              s2_rep_en_r;
  logic              s2_ok_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic [TIME_W-1:0] s2_now_r;
  logic              fwd_r;
  btn_entry_t        fwd_data_r;

  logic [NUM_BUTTONS-1:0] vld_r;
  logic [NUM_BUTTONS-1:0] pressed_r;
  logic [NUM_BUTTONS-1:0] pressed_nxt;
  logic                   inter_r;
  logic                   inter_nxt;

  logic [ENT_W-1:0]  ram_rdata;
  btn_entry_t        ent;
  btn_entry_t        upd_ent;
  btn_entry_t        wr_data;
  logic              upd_deb;
  logic              upd_press;
  logic              wr_en;
  logic [1:0]        fetched;
  logic [LEVELS_W-1:0] levels;

  // output queue
  logic [7:0]  q_data_r [2];
  logic        q_wr_ptr_r;
  logic        q_rd_ptr_r;
  logic [1:0]  occ_r;
  logic        push;
  logic        pop;
  logic [7:0]  res_data;

  assign in_fire    = in_tvalid && in_tready;
  assign issue_last = cur_act_r || (idx_r == ADDR_W'(NUM_BUTTONS - 1));
  // a last read still in the compute stage already counts against the queue
  assign credit_ok  = ({1'b0, occ_r} + {2'b00, s2_valid_r && s2_last_r}) < 3'd2;
  assign issue_fire = cur_valid_r && (!issue_last || credit_ok);
  assign in_tready  = !cur_valid_r || (issue_fire && issue_last);
  assign btn_ok     = {3'b000, cur_btn_r} < 5'(NUM_BUTTONS);
  assign rd_addr    = cur_act_r ? ADDR_W'(cur_btn_r) : idx_r;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      pressed_vec[i] = (i < 4) ? !cur_pins_r[i % 4] : 1'b1;
      rep_vec[i]     = (i < 4) ? mask_r[i % 4] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (in_fire) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (issue_fire && issue_last) begin
      cur_valid_r <= 1'b0;
    end else if (issue_fire) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_act_r  <= in_tuser;
      cur_now_r  <= in_tdata[31:0];
      cur_pins_r <= in_tdata[35:32];
      cur_btn_r  <= in_tdata[37:36];
    end
  end

  dbhr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2_addr_r),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= issue_fire;
    end
  end

  always_ff @(posedge clk) begin
    s2_act_r     <= cur_act_r;
    s2_first_r   <= cur_act_r || (idx_r == '0);
    s2_last_r    <= issue_last;
    s2_btn_ok_r  <= btn_ok;
    s2_pressed_r <= pressed_vec[rd_addr];
    s2_rep_en_r  <= rep_vec[rd_addr];
    s2_ok_r      <= vld_r[rd_addr];
    s2_addr_r    <= rd_addr;
    s2_now_r     <= cur_now_r;
    // same entry written while being read: the ram returns the old word
    fwd_r        <= wr_en && (s2_addr_r == rd_addr);
    fwd_data_r   <= wr_data;
  end

  always_comb begin
    if (fwd_r) begin
      ent = fwd_data_r;
    end else if (s2_ok_r) begin
      ent = btn_entry_t'(ram_rdata);
    end else begin
      ent = '0;
    end
  end

  dbhr_update u_update (
    .ent_i     (ent),
    .deb_i     (pressed_r[s2_addr_r]),
    .pressed_i (s2_pressed_r),
    .rep_en_i  (s2_rep_en_r),
    .now_i     (s2_now_r),
    .cfg_i     (cfg_r),
    .ent_o     (upd_ent),
    .deb_o     (upd_deb),
    .press_o   (upd_press)
  );

  always_comb begin
    wr_en       = s2_valid_r && ((s2_act_r == ITEM_SAMPLE) || s2_btn_ok_r);
    pressed_nxt = pressed_r;
    fetched     = ACT_NONE;
    if (s2_act_r == ITEM_FETCH) begin
      wr_data         = ent;
      wr_data.pending = ACT_NONE;
      if (s2_btn_ok_r) begin
        fetched = ent.pending;
      end
    end else begin
      wr_data                = upd_ent;
      pressed_nxt[s2_addr_r] = upd_deb;
    end
    inter_nxt = (!s2_first_r && inter_r) || ((s2_act_r == ITEM_SAMPLE) && upd_press);
    for (int i = 0; i < LEVELS_W; i++) begin
      levels[i] = (i < NUM_BUTTONS) ? pressed_nxt[i % NUM_BUTTONS] : 1'b0;
    end
    res_data = {1'b0, inter_nxt, levels, fetched};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      pressed_r <= '0;
      inter_r   <= 1'b0;
    end else if (s2_valid_r) begin
      pressed_r <= pressed_nxt;
      inter_r   <= inter_nxt;
      if (wr_en) begin
        vld_r[s2_addr_r] <= 1'b1;
      end
    end
  end

  // two-entry result queue
  assign push       = s2_valid_r && s2_last_r;
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (occ_r != 2'd0);
  assign out_tdata  = q_data_r[q_rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_ptr_r <= 1'b0;
      q_rd_ptr_r <= 1'b0;
      occ_r      <= 2'd0;
    end else begin
      if (push) begin
        q_wr_ptr_r <= !q_wr_ptr_r;
      end
      if (pop) begin
        q_rd_ptr_r <= !q_rd_ptr_r;
      end
      occ_r <= occ_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_data_r[q_wr_ptr_r] <= res_data;
    end
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r != 2'd3)
    else $error("result queue occupancy out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (occ_r != 2'd2) || pop)
    else $error("result pushed into a full queue");

  a_fetch_no_inter: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (s2_act_r == ITEM_FETCH)) |-> !res_data[6])
    else $error("fetch result reports an interaction");

  a_walk_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (issue_fire && !issue_last) |=> cur_valid_r)
    else $error("sample walk dropped before its last button");

  a_fetch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (s2_act_r == ITEM_FETCH)) |-> (wr_data.pending == ACT_NONE))
    else $error("fetch did not clear the pending action");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// testbench for button_debounce_hold_repeat_core: directed table then random sample/fetch traffic
// results checked against an in-bench debounce/hold/repeat predictor; depends on dbhr_pkg
module tb_top;
  import dbhr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 105;

  typedef struct packed {
    logic        act;
    logic [31:0] now;
    logic [3:0]  pins;
    logic [1:0]  btn;
  } button_item_t;

  typedef struct packed {
    logic [1:0] fetched;
    logic [3:0] pressed;
    logic       interaction;
  } button_result_t;

  typedef struct packed {
    button_item_t   it;
    logic           typed;
    button_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // now_ms[31:0], pin_levels[35:32], button[37:36], zero pad
  logic        in_tuser;   // action
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // fetched_action[1:0], pressed_levels[5:2], interaction[6]
  logic        cfg_wr_en;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  button_debounce_hold_repeat_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the block's registers and per-button state
  logic [15:0] cfg_debounce;
  logic [15:0] cfg_hold;
  logic [15:0] cfg_interval;
  logic [3:0]  cfg_mask;
  bit          db_pressed [NUM_BUTTONS];
  logic [31:0] t_change   [NUM_BUTTONS];
  logic [31:0] t_repeat   [NUM_BUTTONS];
  bit          rep_armed  [NUM_BUTTONS];
  logic [1:0]  pend       [NUM_BUTTONS];

  button_result_t results_due [$];
  dir_row_t       dir_rows [$];
  int             items_accepted = 0;
  int             err_count = 0;
  int             cycle_count = 0;
  bit             idle_on = 1'b1;
  logic [31:0]    clock_ms = 32'd0;
  logic [3:0]     levels = 4'hF;

  function automatic void clear_predictor();
    cfg_debounce = 16'd50;
    cfg_hold     = 16'd1000;
    cfg_interval = 16'd200;
    cfg_mask     = 4'd3;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      db_pressed[i] = 1'b0;
      t_change[i]   = '0;
      t_repeat[i]   = '0;
      rep_armed[i]  = 1'b0;
      pend[i]       = ACT_NONE;
    end
  endfunction

  function automatic button_result_t debounce_predict(input button_item_t it);
    button_result_t r;
    logic [31:0] since;
    logic [31:0] since_rep;
    bit pr;
    bit en;
    r = '0;
    if (it.act == ITEM_FETCH) begin
      if (it.btn < NUM_BUTTONS) begin
        r.fetched = pend[it.btn];
        pend[it.btn] = ACT_NONE;
      end
    end else begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        pr = (i < LEVELS_W) ? !it.pins[i] : 1'b1;
        en = (i < MASK_W) ? cfg_mask[i] : 1'b0;
        since = it.now - t_change[i];
        since_rep = it.now - t_repeat[i];
        if (pr != db_pressed[i]) begin
          if (since > {16'd0, cfg_debounce}) begin
            db_pressed[i] = pr;
            t_change[i] = it.now;
            if (pr) begin
              pend[i] = ACT_PRESS;
              r.interaction = 1'b1;
            end else begin
              pend[i] = ACT_RELEASE;
              rep_armed[i] = 1'b0;
            end
          end
        end else if (pr) begin
          if (since > {16'd0, cfg_hold}) begin
            pend[i] = ACT_HOLD;
            if (en) rep_armed[i] = 1'b1;
          end
          // a repeat press wins over hold in the same sample
          if (rep_armed[i] && en && since_rep > {16'd0, cfg_interval}) begin
            pend[i] = ACT_PRESS;
            t_repeat[i] = it.now;
            r.interaction = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < NUM_BUTTONS && i < 4; i++) r.pressed[i] = db_pressed[i];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic void dir_row(input logic act, input logic [31:0] now, input logic [3:0] pins,
                                  input logic [1:0] btn, input logic typed,
                                  input logic [1:0] fetched, input logic [3:0] pressed,
                                  input logic inter);
    dir_row_t row;
    row.it = '{act: act, now: now, pins: pins, btn: btn};
    row.typed = typed;
    row.res = '{fetched: fetched, pressed: pressed, interaction: inter};
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(input button_item_t it, input logic typed,
                           input button_result_t typed_res);
    int gap;
    button_result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.act;
    in_tdata  <= {2'b00, it.btn, it.pins, it.now};
    do @(posedge clk); while (!in_tready);
    items_accepted++;
    pred = debounce_predict(it);
    results_due.push_back(typed ? typed_res : pred);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DEBOUNCE: cfg_debounce = val;
      CFG_HOLD:     cfg_hold = val;
      CFG_INTERVAL: cfg_interval = val;
      CFG_MASK:     cfg_mask = val[3:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (results_due.size() != 0) @(posedge clk);
    repeat (NUM_BUTTONS + 4) @(posedge clk);
  endtask

  // mostly steady pins with time moving in steps scaled to the current timing,
  // plus bounces, wild jumps and the odd step backwards
  task automatic run_random(input int n_items);
    button_item_t it;
    int r;
    int b;
    for (int k = 0; k < n_items; k++) begin
      it.now  = $urandom;
      it.pins = 4'($urandom);
      it.btn  = 2'($urandom);
      r = $urandom_range(0, 99);
      if (r < 30) begin
        it.act = ITEM_FETCH;
      end else begin
        it.act = ITEM_SAMPLE;
        r = $urandom_range(0, 99);
        if (r < 40) clock_ms += $urandom_range(0, cfg_debounce + 3);
        else if (r < 72) clock_ms += $urandom_range(0, cfg_interval + 10);
        else if (r < 94) clock_ms += $urandom_range(0, cfg_hold + 20);
        else if (r < 97) clock_ms += $urandom;
        else clock_ms -= $urandom_range(0, cfg_debounce + 3);
        r = $urandom_range(0, 99);
        b = $urandom_range(0, 3);
        if (r >= 90) levels = 4'($urandom);
        else if (r >= 65) levels[b] = ~levels[b];
        it.now  = clock_ms;
        it.pins = levels;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int stall;
    bit long_done;
    long_done = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = pick_gap();
      if (!long_done && items_accepted >= 400) begin
        stall = 300;
        long_done = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    button_result_t got;
    button_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{fetched: out_tdata[1:0], pressed: out_tdata[5:2], interaction: out_tdata[6]};
      if (results_due.size() == 0) begin
        $error("result transfer with nothing expected: out_tdata %h", out_tdata);
        err_count++;
      end else begin
        want = results_due.pop_front();
        if (got.fetched !== want.fetched) begin
          $error("fetched_action: expected %0d, got %0d", want.fetched, got.fetched);
          err_count++;
        end
        if (got.pressed !== want.pressed) begin
          $error("pressed_levels: expected %h, got %h", want.pressed, got.pressed);
          err_count++;
        end
        if (got.interaction !== want.interaction) begin
          $error("interaction: expected %0d, got %0d", want.interaction, got.interaction);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ITEM_SAMPLE;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= CFG_DEBOUNCE;
    cfg_wdata <= '0;
    clear_predictor();

    // act, now, pins, btn, typed, fetched, pressed, interaction
    dir_row(ITEM_FETCH,  32'd0,    4'hF, 2'd0, 1, ACT_NONE,  4'h0, 0);
    dir_row(ITEM_SAMPLE, 32'd50,   4'h0, 2'd0, 1, ACT_NONE,  4'h0, 0); // exactly debounce: too soon
    dir_row(ITEM_SAMPLE, 32'd51,   4'hE, 2'd3, 1, ACT_NONE,  4'h1, 1);
    dir_row(ITEM_FETCH,  32'd0,    4'hF, 2'd0, 1, ACT_PRESS, 4'h1, 0);
    dir_row(ITEM_FETCH,  32'd0,    4'hF, 2'd0, 1, ACT_NONE,  4'h1, 0); // fetch cleared it
    dir_row(ITEM_SAMPLE, 32'd60,   4'hF, 2'd0, 0, 0, 0, 0);           // bounce ignored
    dir_row(ITEM_SAMPLE, 32'd1052, 4'hE, 2'd0, 0, 0, 0, 0);           // repeat beats hold
    dir_row(ITEM_FETCH,  32'd0,    4'hF, 2'd0, 0, 0, 0, 0);
    dir_row(ITEM_SAMPLE, 32'd1100, 4'hE, 2'd0, 0, 0, 0, 0);           // hold only
    dir_row(ITEM_FETCH,  32'd0,    4'hF, 2'd0, 0, 0, 0, 0);
    dir_row(ITEM_SAMPLE, 32'd1300, 4'hE, 2'd0, 0, 0, 0, 0);           // repeat press
    dir_row(ITEM_SAMPLE, 32'd2000, 4'hF, 2'd0, 0, 0, 0, 0);           // release disarms repeat
    dir_row(ITEM_FETCH,  32'd0,    4'hF, 2'd0, 0, 0, 0, 0);
    dir_row(ITEM_SAMPLE, 32'hFFFF_FFF0, 4'h0, 2'd0, 0, 0, 0, 0);
    dir_row(ITEM_SAMPLE, 32'hFFFF_FFFF, 4'h0, 2'd0, 0, 0, 0, 0);
    dir_row(ITEM_SAMPLE, 32'h0000_0010, 4'h0, 2'd0, 0, 0, 0, 0);      // time wraps
    dir_row(ITEM_SAMPLE, 32'h0000_0500, 4'h0, 2'd0, 0, 0, 0, 0);
    dir_row(ITEM_FETCH,  32'd0,    4'hF, 2'd0, 0, 0, 0, 0);
    dir_row(ITEM_FETCH,  32'd0,    4'hF, 2'd1, 0, 0, 0, 0);
    dir_row(ITEM_FETCH,  32'd0,    4'hF, 2'd2, 0, 0, 0, 0);
    dir_row(ITEM_FETCH,  32'd0,    4'hF, 2'd3, 0, 0, 0, 0);
    dir_row(ITEM_SAMPLE, 32'h0000_0600, 4'hF, 2'd0, 0, 0, 0, 0);
    dir_row(ITEM_FETCH,  32'd0,    4'hF, 2'd3, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < dir_rows.size(); n++)
      send_item(dir_rows[n].it, dir_rows[n].typed, dir_rows[n].res);
    in_tvalid <= 1'b0;
    clock_ms = 32'h0000_0600;

    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      drain();
      idle_on = (ph % 3) != 0;
      case (ph)
        1: begin
          write_reg(CFG_DEBOUNCE, 16'd0);
          write_reg(CFG_HOLD, 16'd0);
          write_reg(CFG_INTERVAL, 16'd0);
          write_reg(CFG_MASK, 16'h000F);
        end
        2: begin
          write_reg(CFG_DEBOUNCE, 16'hFFFF);
          write_reg(CFG_HOLD, 16'hFFFF);
          write_reg(CFG_INTERVAL, 16'hFFFF);
          write_reg(CFG_MASK, 16'h0000);
        end
        3: begin
          write_reg(CFG_DEBOUNCE, 16'd20);
          write_reg(CFG_HOLD, 16'd300);
          write_reg(CFG_INTERVAL, 16'd50);
          write_reg(CFG_MASK, 16'hFFF5); // upper bits dropped
        end
        default: begin
          write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 100)));
          write_reg(CFG_HOLD, 16'($urandom_range(0, 1500)));
          write_reg(CFG_INTERVAL, 16'($urandom_range(0, 400)));
          write_reg(CFG_MASK, 16'($urandom));
        end
      endcase
      cfg_wr_en <= 1'b0;
      run_random(ITEMS_PER_PHASE);
      in_tvalid <= 1'b0;
    end

    drain();
    repeat (NUM_BUTTONS + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
